// File: rtl/lbs_pkg.sv
// Package for the LED blink sequencer: sizes, command and register codes,
// and the structs passed between the top level and the per-LED cells.
// No dependencies.
package lbs_pkg;

   localparam int NUM_LEDS   = 8;
   localparam int FUNC_W     = 3;
   localparam int INDEX_W    = 3;
   localparam int PROG_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [PROG_W-1:0] PROG_ON  = 8'hFF;
   localparam logic [PROG_W-1:0] PROG_OFF = 8'h00;

   localparam logic [PROG_W-1:0] COUNT_MASK_RESET  = 8'd127;
   localparam logic [PROG_W-1:0] END_ON_MASK_RESET = 8'd128;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK      = 3'd0,
      FUNC_ENABLE    = 3'd1,
      FUNC_SET_ON    = 3'd2,
      FUNC_SET_OFF   = 3'd3,
      FUNC_SET_BLINK = 3'd4
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_LOW  = 2'd0,
      CSR_COUNT_MASK  = 2'd1,
      CSR_END_ON_MASK = 2'd2
   } csr_index_type;

   // Decoded command, broadcast to every cell.
   typedef struct packed {
      logic              tick;
      logic              enable;
      logic              write_prog;
      logic [PROG_W-1:0] prog_value;
   } led_cmd_type;

   typedef struct packed {
      logic              active_low;
      logic [PROG_W-1:0] count_mask;
      logic [PROG_W-1:0] end_on_mask;
   } led_cfg_type;

   // State of one LED after the current transaction has been applied.
   typedef struct packed {
      logic lit;
      logic port;
      logic enabled;
   } led_status_type;

endpackage

// File: rtl/lbs_req_if.sv
// Handshake interfaces for the command channel and the result channel
// of the LED blink sequencer. Depends on lbs_pkg.
interface lbs_req_if
   import lbs_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [INDEX_W-1:0]   led_index;
   logic [PROG_W-1:0]    program_value;

   modport source (output valid, func, led_index, program_value, input ready);
   modport sink   (input valid, func, led_index, program_value, output ready);
endinterface

interface lbs_rsp_if
   import lbs_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [NUM_LEDS-1:0]  lit_mask;
   logic [NUM_LEDS-1:0]  pin_levels;
   logic [NUM_LEDS-1:0]  enabled_mask;

   modport source (output valid, lit_mask, pin_levels, enabled_mask, input ready);
   modport sink   (input valid, lit_mask, pin_levels, enabled_mask, output ready);
endinterface

// File: rtl/lbs_led_cell.sv
// State and update logic of one LED: program byte, blink count, enable, lit
// and port bits. Depends on lbs_pkg.
module lbs_led_cell
   import lbs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           sel,
   input  led_cmd_type    cmd,
   input  led_cfg_type    cfg,
   output led_status_type status
);

   logic               enabled_ff, enabled_in;
   logic [PROG_W-1:0]  prog_ff, prog_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               lit_ff, lit_in;
   logic               port_ff, port_in;
   logic [COUNT_W-1:0] count_inc;

   assign count_inc = count_ff + COUNT_W'(1);

   always_comb begin
      enabled_in = enabled_ff;
      prog_in    = prog_ff;
      count_in   = count_ff;
      lit_in     = lit_ff;
      port_in    = port_ff;
      if (cmd.tick) begin
         // Disabled LEDs hold their lit and port bits through a tick.
         if (enabled_ff) begin
            priority if (prog_ff == PROG_ON) begin
               lit_in = 1'b1;
            end else if (prog_ff == PROG_OFF) begin
               lit_in = 1'b0;
            end else if (lit_ff) begin
               lit_in = 1'b0;
            end else begin
               count_in = count_inc;
               if (count_inc <= (prog_ff & cfg.count_mask)) begin
                  lit_in = 1'b1;
               end else if ((prog_ff & cfg.end_on_mask) != PROG_OFF) begin
                  lit_in  = 1'b1;
                  prog_in = PROG_ON;
               end else begin
                  lit_in = 1'b0;
               end
            end
            port_in = lit_in ^ cfg.active_low;
         end
      end else if (sel) begin
         if (cmd.enable) begin
            enabled_in = 1'b1;
         end
         if (cmd.write_prog) begin
            prog_in  = cmd.prog_value;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         prog_ff    <= PROG_OFF;
         count_ff   <= '0;
         lit_ff     <= 1'b0;
         port_ff    <= 1'b0;
      end else if (step) begin
         enabled_ff <= enabled_in;
         prog_ff    <= prog_in;
         count_ff   <= count_in;
         lit_ff     <= lit_in;
         port_ff    <= port_in;
      end
   end

   assign status.lit     = lit_in;
   assign status.port    = port_in;
   assign status.enabled = enabled_in;

endmodule

// File: rtl/led_blink_sequencer.sv
// Top level of the LED blink sequencer: command register, decode, the row of
// LED cells, the result register and the register port. Depends on lbs_pkg,
// lbs_req_if, lbs_rsp_if and lbs_led_cell.

// Each command transaction produces exactly one result transaction, which
// reports the lit mask, the pin levels and the enabled mask as they stand after
// the command. A transaction is captured in a command register, then applied to
// the LED cells while its result is stored in an output register in the same
// cycle, and a new transaction is taken every cycle while the result side keeps
// up. Register writes should be made while the block is idle; a change of
// polarity reaches the pins only at the next tick.
module led_blink_sequencer
   import lbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lbs_req_if.sink               req_chan,
   lbs_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic                 in_valid_ff;
   logic [FUNC_W-1:0]    in_func_ff;
   logic [INDEX_W-1:0]   in_index_ff;
   logic [PROG_W-1:0]    in_prog_ff;

   logic                 out_valid_ff;
   logic [NUM_LEDS-1:0]  out_lit_ff, out_lit_in;
   logic [NUM_LEDS-1:0]  out_port_ff, out_port_in;
   logic [NUM_LEDS-1:0]  out_en_ff, out_en_in;

   led_cfg_type          cfg_ff;
   led_cmd_type          cmd;
   logic                 advance;
   logic                 index_ok;
   led_status_type       status [NUM_LEDS];

   // The command stage moves on whenever the result register is free or
   // being emptied in the same cycle.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_func_ff  <= req_chan.func;
         in_index_ff <= req_chan.led_index;
         in_prog_ff  <= req_chan.program_value;
      end
   end

   assign index_ok = ({1'b0, in_index_ff} < (INDEX_W + 1)'(NUM_LEDS));

   always_comb begin
      cmd = '0;
      case (func_type'(in_func_ff))
         FUNC_TICK: begin
            cmd.tick = 1'b1;
         end
         FUNC_ENABLE: begin
            cmd.enable     = index_ok;
            cmd.write_prog = index_ok;
            cmd.prog_value = PROG_OFF;
         end
         FUNC_SET_ON: begin
            cmd.write_prog = index_ok;
            cmd.prog_value = PROG_ON;
         end
         FUNC_SET_OFF: begin
            cmd.write_prog = index_ok;
            cmd.prog_value = PROG_OFF;
         end
         FUNC_SET_BLINK: begin
            cmd.write_prog = index_ok;
            cmd.prog_value = in_prog_ff;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
      lbs_led_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .step   (advance),
         .sel    (in_index_ff == INDEX_W'(i)),
         .cmd    (cmd),
         .cfg    (cfg_ff),
         .status (status[i])
      );
      assign out_lit_in[i]  = status[i].lit;
      assign out_port_in[i] = status[i].port;
      assign out_en_in[i]   = status[i].enabled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_lit_ff  <= out_lit_in;
         out_port_ff <= out_port_in;
         out_en_ff   <= out_en_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.lit_mask     = out_lit_ff;
   assign rsp_chan.pin_levels   = out_port_ff;
   assign rsp_chan.enabled_mask = out_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low  <= 1'b0;
         cfg_ff.count_mask  <= COUNT_MASK_RESET;
         cfg_ff.end_on_mask <= END_ON_MASK_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ACTIVE_LOW:  cfg_ff.active_low  <= csr_write_data[0];
            CSR_COUNT_MASK:  cfg_ff.count_mask  <= csr_write_data;
            CSR_END_ON_MASK: cfg_ff.end_on_mask <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

endmodule

// File: dv/led_blink_sequencer_tb.sv
// Self-checking testbench for led_blink_sequencer: drives command transactions,
// predicts every LED's state per command and checks each result transaction.
// Depends on lbs_pkg, lbs_req_if, lbs_rsp_if and the RTL of the block.
module led_blink_sequencer_tb
   import lbs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 10;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 6;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int PHASE_ITEMS     = 190;

   // Command codes that the block decodes to nothing.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_MID   = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [NUM_LEDS-1:0] lit;
      logic [NUM_LEDS-1:0] pins;
      logic [NUM_LEDS-1:0] enabled;
   } led_snapshot_type;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   lbs_req_if req_bus ();
   lbs_rsp_if rsp_bus ();

   led_blink_sequencer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Predicted state of the LED row and its registers.
   logic [NUM_LEDS-1:0] model_enabled;
   logic [NUM_LEDS-1:0] model_lit;
   logic [NUM_LEDS-1:0] model_pins;
   logic [PROG_W-1:0]   model_prog [NUM_LEDS];
   logic [COUNT_W-1:0]  model_count [NUM_LEDS];
   logic                cfg_active_low;
   logic [PROG_W-1:0]   cfg_count_mask;
   logic [PROG_W-1:0]   cfg_end_on_mask;

   led_snapshot_type pending_snapshots [$];
   int               mismatch_count;
   int               cycle_count;
   int               burst_left;
   bit               hold_off_req;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("led_blink_sequencer_tb: errors");
         $finish;
      end
   end

   function automatic led_snapshot_type apply_command(input logic [FUNC_W-1:0]  func,
                                                      input logic [INDEX_W-1:0] idx,
                                                      input logic [PROG_W-1:0]  value);
      logic              on;
      logic [PROG_W-1:0] prog;
      if (func == FUNC_TICK) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            if (model_enabled[i]) begin
               prog = model_prog[i];
               on   = 1'b0;
               if (prog == PROG_ON) begin
                  on = 1'b1;
               end else if (prog == PROG_OFF) begin
                  on = 1'b0;
               end else if (model_lit[i]) begin
                  on = 1'b0;
               end else begin
                  model_count[i] = model_count[i] + 1'b1;
                  if (model_count[i] <= (prog & cfg_count_mask)) begin
                     on = 1'b1;
                  end else if ((prog & cfg_end_on_mask) != '0) begin
                     // Blinking is over and the LED latches on for good.
                     on            = 1'b1;
                     model_prog[i] = PROG_ON;
                  end
               end
               model_lit[i]  = on;
               model_pins[i] = on ^ cfg_active_low;
            end
         end
      end else if (int'(idx) < NUM_LEDS) begin
         case (func)
            FUNC_ENABLE: begin
               model_enabled[idx] = 1'b1;
               model_prog[idx]    = PROG_OFF;
               model_count[idx]   = '0;
            end
            FUNC_SET_ON: begin
               model_prog[idx]  = PROG_ON;
               model_count[idx] = '0;
            end
            FUNC_SET_OFF: begin
               model_prog[idx]  = PROG_OFF;
               model_count[idx] = '0;
            end
            FUNC_SET_BLINK: begin
               model_prog[idx]  = value;
               model_count[idx] = '0;
            end
            default: ;
         endcase
      end
      return '{lit: model_lit, pins: model_pins, enabled: model_enabled};
   endfunction

   function automatic void check_field(input string name,
                                       input logic [NUM_LEDS-1:0] expected_value,
                                       input logic [NUM_LEDS-1:0] actual_value);
      if (actual_value !== expected_value) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, expected_value, actual_value);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      led_snapshot_type expected_snapshot;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_snapshots.size() == 0) begin
            $error("result transaction with no command outstanding");
            mismatch_count++;
         end else begin
            expected_snapshot = pending_snapshots.pop_front();
            check_field("lit_mask", expected_snapshot.lit, rsp_bus.lit_mask);
            check_field("pin_levels", expected_snapshot.pins, rsp_bus.pin_levels);
            check_field("enabled_mask", expected_snapshot.enabled, rsp_bus.enabled_mask);
         end
      end
   end

   // Result side: a rotating stall pattern, or one long hold-off on request.
   initial begin
      logic [7:0] stall_pattern;
      int         phase;
      stall_pattern   = 8'hFF;
      phase           = 0;
      rsp_bus.ready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_bus.ready = stall_pattern[phase];
            phase         = (phase + 1) % 8;
            if (phase == 0 && $urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pattern = 8'($urandom);
                  1:       stall_pattern = 8'($urandom) | 8'($urandom);
                  default: stall_pattern = 8'hFF;
               endcase
            end
         end
      end
   end

   task automatic send_command(input logic [FUNC_W-1:0]  func,
                               input logic [INDEX_W-1:0] idx,
                               input logic [PROG_W-1:0]  value);
      @(negedge clock);
      req_bus.valid         = 1'b1;
      req_bus.func          = func;
      req_bus.led_index     = idx;
      req_bus.program_value = value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_snapshots.push_back(apply_command(func, idx, value));
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_W'($urandom);
      req_bus.led_index     = INDEX_W'($urandom);
      req_bus.program_value = PROG_W'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Bursts of random length separated by random gaps.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0)
            idle_sender(gap);
         burst_left = $urandom_range(1, 30);
      end else begin
         burst_left--;
      end
   endtask

   // Registers change only when no transaction is in flight.
   task automatic set_config(input logic              active_low,
                             input logic [PROG_W-1:0] count_mask,
                             input logic [PROG_W-1:0] end_on_mask);
      idle_sender(1);
      while (pending_snapshots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_index      = CSR_ACTIVE_LOW;
      csr_write_data = CSR_DATA_W'(active_low);
      @(negedge clock);
      csr_index      = CSR_COUNT_MASK;
      csr_write_data = count_mask;
      @(negedge clock);
      csr_index      = CSR_END_ON_MASK;
      csr_write_data = end_on_mask;
      @(negedge clock);
      csr_write_en   = 1'b0;
      cfg_active_low  = active_low;
      cfg_count_mask  = count_mask;
      cfg_end_on_mask = end_on_mask;
   endtask

   task automatic send_random_command();
      int                 sel;
      logic [FUNC_W-1:0]  func;
      logic [PROG_W-1:0]  value;
      sel = $urandom_range(0, 99);
      if (sel < 45)
         func = FUNC_TICK;
      else if (sel < 55)
         func = FUNC_ENABLE;
      else if (sel < 63)
         func = FUNC_SET_ON;
      else if (sel < 71)
         func = FUNC_SET_OFF;
      else if (sel < 93)
         func = FUNC_SET_BLINK;
      else
         func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      // Short blink counts finish within a few ticks; full bytes cover every bit.
      if ($urandom_range(0, 1))
         value = PROG_W'($urandom);
      else
         value = ($urandom_range(0, 1) ? 8'h80 : 8'h00) | PROG_W'($urandom_range(1, 6));
      send_command(func, INDEX_W'($urandom_range(0, NUM_LEDS - 1)), value);
   endtask

   task automatic test_directed_commands();
      send_command(FUNC_TICK, 3'd0, 8'h00);
      send_command(FUNC_ENABLE, 3'd0, 8'hFF);
      send_command(FUNC_ENABLE, 3'd7, 8'h00);
      send_command(FUNC_SET_ON, 3'd0, 8'h00);
      send_command(FUNC_TICK, 3'd5, 8'hFF);
      // One blink, then the end-on flag latches the LED on.
      send_command(FUNC_SET_BLINK, 3'd7, 8'h81);
      repeat (4) send_command(FUNC_TICK, 3'd0, 8'h00);
      send_command(FUNC_SET_BLINK, 3'd0, PROG_OFF);
      send_command(FUNC_SET_BLINK, 3'd7, PROG_ON);
      send_command(FUNC_TICK, 3'd0, 8'h00);
      // A disabled LED takes its program but ignores ticks until enabled.
      send_command(FUNC_SET_ON, 3'd3, 8'h00);
      send_command(FUNC_TICK, 3'd0, 8'h00);
      send_command(FUNC_ENABLE, 3'd3, 8'h00);
      send_command(FUNC_TICK, 3'd0, 8'h00);
      send_command(FUNC_SET_OFF, 3'd0, 8'h00);
      send_command(FUNC_SPARE_FIRST, 3'd2, 8'hAA);
      send_command(FUNC_SPARE_MID, 3'd0, 8'h00);
      send_command(FUNC_SPARE_LAST, 3'd7, 8'h55);
      send_command(FUNC_SET_BLINK, 3'd3, 8'h02);
      repeat (3) send_command(FUNC_TICK, 3'd7, 8'hFF);
   endtask

   task automatic test_polarity_change();
      set_config(1'b1, COUNT_MASK_RESET, END_ON_MASK_RESET);
      send_command(FUNC_ENABLE, 3'd5, 8'h00);
      send_command(FUNC_SET_ON, 3'd5, 8'h00);
      send_command(FUNC_SET_ON, 3'd2, 8'h00);
      send_command(FUNC_TICK, 3'd0, 8'h00);
      set_config(1'b0, COUNT_MASK_RESET, END_ON_MASK_RESET);
      send_command(FUNC_SPARE_FIRST, 3'd5, 8'h00);
      send_command(FUNC_TICK, 3'd0, 8'h00);
   endtask

   // Enough dark ticks for the blink count to wrap past 255 back to zero.
   task automatic test_count_wrap();
      set_config(1'b0, 8'hFF, 8'h00);
      send_command(FUNC_ENABLE, 3'd1, 8'h00);
      send_command(FUNC_SET_BLINK, 3'd1, 8'h03);
      send_command(FUNC_SET_BLINK, 3'd6, 8'hFE);
      send_command(FUNC_ENABLE, 3'd6, 8'h00);
      send_command(FUNC_SET_BLINK, 3'd6, 8'hFE);
      repeat (300) begin
         send_command(FUNC_TICK, INDEX_W'($urandom), PROG_W'($urandom));
         pace_sender();
      end
   endtask

   task automatic test_back_pressure();
      set_config(1'b1, COUNT_MASK_RESET, END_ON_MASK_RESET);
      @(posedge clock);
      hold_off_req = 1'b1;
      repeat (40) send_random_command();
   endtask

   task automatic run_random_phase(input int items);
      repeat (items) begin
         send_random_command();
         pace_sender();
      end
   endtask

   task automatic test_random_traffic();
      set_config(1'b0, COUNT_MASK_RESET, END_ON_MASK_RESET);
      run_random_phase(PHASE_ITEMS);
      set_config(1'b1, 8'h00, 8'h00);
      run_random_phase(PHASE_ITEMS);
      set_config(1'b1, 8'hFF, 8'hFF);
      run_random_phase(PHASE_ITEMS);
      set_config(1'b0, PROG_W'($urandom), PROG_W'($urandom));
      run_random_phase(PHASE_ITEMS);
      set_config(1'($urandom_range(0, 1)), 8'h07, 8'h40);
      run_random_phase(PHASE_ITEMS);
   endtask

   initial begin
      mismatch_count        = 0;
      cycle_count           = 0;
      burst_left            = 0;
      hold_off_req          = 1'b0;
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_index             = CSR_ACTIVE_LOW;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_TICK;
      req_bus.led_index     = '0;
      req_bus.program_value = '0;
      model_enabled         = '0;
      model_lit             = '0;
      model_pins            = '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
         model_prog[i]  = PROG_OFF;
         model_count[i] = '0;
      end
      cfg_active_low  = 1'b0;
      cfg_count_mask  = COUNT_MASK_RESET;
      cfg_end_on_mask = END_ON_MASK_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_commands();
      test_polarity_change();
      test_count_wrap();
      test_back_pressure();
      test_random_traffic();

      idle_sender(1);
      while (pending_snapshots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("led_blink_sequencer_tb: clean");
      else
         $display("led_blink_sequencer_tb: errors");
      $finish;
   end

endmodule

// File: led_blink_sequencer.f
rtl/lbs_pkg.sv
rtl/lbs_req_if.sv
rtl/lbs_led_cell.sv
rtl/led_blink_sequencer.sv
dv/led_blink_sequencer_tb.sv
